### src/gvn_pkg.sv
// grid vertex normals: shared package
// types, widths, codes and command/status structs used by every module
// depends on nothing
package gvn_pkg;

  localparam int MAX_U_DEF = 64;
  localparam int MAX_V_DEF = 64;
  localparam int MAX_T_DEF = 4;

  localparam int POS_W  = 24;
  localparam int DIFF_W = 25;
  localparam int WORD_W = 3 * POS_W;
  localparam int MUL_W  = 31;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = 53;
  localparam int MAG_W  = 52;
  localparam int NRM_W  = 30;
  localparam int LEN_W  = 31;
  localparam int ROOT_W = 63;
  localparam int FRAC_W = 14;
  localparam int DIV_W  = LEN_W + FRAC_W;
  localparam int QUO_W  = 15;
  localparam int OUT_W  = 16;
  localparam int CNT_W  = 5;

  localparam int N_READS    = 5;
  localparam int N_TERMS    = 6;
  localparam int N_PAIRS    = 4;
  localparam int N_COMP     = 3;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_SAMPLES = 2'd2;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [2:0] SEL_CENTRE = 3'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_RDWAIT,
    S_CROSS,
    S_CROSS_ACC,
    S_ABS,
    S_NORM,
    S_SQ,
    S_SQ_ACC,
    S_SQRT_INIT,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_DIV_ST,
    S_OUT
  } gvn_state_t;

  typedef struct packed {
    logic                    command;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } gvn_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    zero_normal;
    logic                    last_of_grid;
  } gvn_out_t;

  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       ld_flags;
    logic [3:0] av;
    logic       last;
    logic       mul_en;
    logic       mul_sq;
    logic [1:0] idx;
    logic [2:0] term;
    logic       abs_en;
    logic       norm_en;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       out_load;
  } gvn_cmd_t;

  typedef struct packed {
    logic zero;
    logic norm_ok;
    logic out_free;
  } gvn_sts_t;

endpackage

### src/gvn_dp.sv
// grid vertex normals: datapath
// vertex window memory, shared multiplier, normalise, square root and divide units
// depends on gvn_pkg
module gvn_dp #(
  parameter int MAX_U = gvn_pkg::MAX_U_DEF,
  parameter int MAX_T = gvn_pkg::MAX_T_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gvn_pkg::gvn_in_t            in_data,
  input  gvn_pkg::gvn_cmd_t           cmd,
  input  logic [$clog2(2*MAX_U*MAX_T+1)-1:0] rd_off,
  output gvn_pkg::gvn_sts_t           sts,
  input  logic                        out_stall,
  output logic                        out_valid,
  output gvn_pkg::gvn_out_t           out_data
);

  localparam int WIN  = 2 * MAX_U * MAX_T + 1;
  localparam int AW   = $clog2(WIN);
  localparam int AW1  = AW + 1;
  localparam int PW   = gvn_pkg::POS_W;
  localparam int DW   = gvn_pkg::DIFF_W;
  localparam int MW   = gvn_pkg::MUL_W;
  localparam int PRW  = gvn_pkg::PROD_W;
  localparam int SW   = gvn_pkg::SUM_W;
  localparam int GW   = gvn_pkg::MAG_W;
  localparam int NW   = gvn_pkg::NRM_W;
  localparam int LW   = gvn_pkg::LEN_W;
  localparam int RTW  = gvn_pkg::ROOT_W;
  localparam int FW   = gvn_pkg::FRAC_W;
  localparam int VW   = gvn_pkg::DIV_W;
  localparam int QW   = gvn_pkg::QUO_W;
  localparam int OW   = gvn_pkg::OUT_W;

  // window store
  logic [gvn_pkg::WORD_W-1:0] mem [WIN];
  logic [gvn_pkg::WORD_W-1:0] rdata_r;
  logic [AW-1:0]              head_r, head_nxt, raddr;
  logic [AW1-1:0]             diff, wrapped;
  logic                       cap_en_r;
  logic [2:0]                 cap_sel_r;

  assign head_nxt = (head_r == AW'(WIN - 1)) ? '0 : head_r + AW'(1);
  assign diff     = {1'b0, head_r} - {1'b0, rd_off};
  assign wrapped  = diff + AW1'(WIN);
  assign raddr    = diff[AW] ? wrapped[AW-1:0] : diff[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[head_nxt] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= AW'(WIN - 1);
      cap_en_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        head_r <= head_nxt;
      end
      cap_en_r <= cmd.rd_en;
    end
  end

  // centre sample and neighbour difference vectors
  logic signed [PW-1:0] ctr_r [3];
  logic signed [PW-1:0] nb [3];
  logic signed [DW-1:0] v_r [4][3];
  logic [3:0]           av_r;
  logic                 last_r;
  logic [1:0]           nbi;

  assign nb[0] = rdata_r[3*PW-1:2*PW];
  assign nb[1] = rdata_r[2*PW-1:PW];
  assign nb[2] = rdata_r[PW-1:0];
  assign nbi   = cap_sel_r[1:0] - 2'd1;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      cap_sel_r <= cmd.rd_sel;
    end
    if (cmd.ld_flags) begin
      av_r   <= cmd.av;
      last_r <= cmd.last;
    end
    if (cap_en_r) begin
      if (cap_sel_r == gvn_pkg::SEL_CENTRE) begin
        for (int c = 0; c < 3; c++) begin
          ctr_r[c] <= nb[c];
        end
      end else begin
        for (int c = 0; c < 3; c++) begin
          v_r[nbi][c] <= av_r[nbi] ? ({nb[c][PW-1], nb[c]} - {ctr_r[c][PW-1], ctr_r[c]})
                                   : '0;
        end
      end
    end
  end

  // shared multiplier operand selection
  logic signed [DW-1:0] a_vec [3];
  logic signed [DW-1:0] b_vec [3];
  logic signed [DW-1:0] ta, tb;
  logic signed [MW-1:0] op_a, op_b;
  logic                 pair_on;
  logic [GW-1:0]        m_r [3];

  always_comb begin
    a_vec   = v_r[0];
    b_vec   = v_r[1];
    pair_on = av_r[0] & av_r[1];
    case (cmd.idx)
      2'd0: begin
        a_vec = v_r[0]; b_vec = v_r[1]; pair_on = av_r[0] & av_r[1];
      end
      2'd1: begin
        a_vec = v_r[1]; b_vec = v_r[2]; pair_on = av_r[1] & av_r[2];
      end
      2'd2: begin
        a_vec = v_r[2]; b_vec = v_r[3]; pair_on = av_r[2] & av_r[3];
      end
      2'd3: begin
        a_vec = v_r[3]; b_vec = v_r[0]; pair_on = av_r[3] & av_r[0];
      end
      default: ;
    endcase
    case (cmd.term)
      3'd0: begin ta = a_vec[1]; tb = b_vec[2]; end
      3'd1: begin ta = a_vec[2]; tb = b_vec[1]; end
      3'd2: begin ta = a_vec[2]; tb = b_vec[0]; end
      3'd3: begin ta = a_vec[0]; tb = b_vec[2]; end
      3'd4: begin ta = a_vec[0]; tb = b_vec[1]; end
      3'd5: begin ta = a_vec[1]; tb = b_vec[0]; end
      default: begin ta = '0; tb = '0; end
    endcase
    if (cmd.mul_sq) begin
      op_a = $signed({1'b0, m_r[cmd.idx][NW-1:0]});
      op_b = $signed({1'b0, m_r[cmd.idx][NW-1:0]});
    end else begin
      op_a = MW'(ta);
      op_b = MW'(tb);
    end
  end

  logic signed [PRW-1:0] prod_r;
  logic                  pv_r, psq_r, pneg_r;
  logic [1:0]            pcomp_r;
  logic signed [SW-1:0]  padd;
  logic signed [SW-1:0]  s_r [3];
  logic [PRW-1:0]        qacc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mul_en & (cmd.mul_sq | pair_on);
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= op_a * op_b;
    psq_r   <= cmd.mul_sq;
    pneg_r  <= cmd.term[0];
    pcomp_r <= cmd.term[2:1];
  end

  assign padd = pneg_r ? -$signed(prod_r[SW-1:0]) : $signed(prod_r[SW-1:0]);

  // magnitude, normalise shift, square sum
  logic [GW-1:0] or_m;
  logic          hi, zero_r;
  logic [2:0]    neg_r;

  assign or_m = m_r[0] | m_r[1] | m_r[2];
  assign hi   = |or_m[GW-1:NW];

  always_ff @(posedge clk) begin
    if (cmd.ld_flags) begin
      for (int k = 0; k < 3; k++) begin
        s_r[k] <= '0;
      end
    end else if (pv_r && !psq_r) begin
      s_r[pcomp_r] <= s_r[pcomp_r] + padd;
    end
    if (cmd.abs_en) begin
      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= s_r[k][SW-1];
        m_r[k]   <= s_r[k][SW-1] ? GW'(-s_r[k]) : GW'(s_r[k]);
      end
      zero_r <= (s_r[0] == '0) && (s_r[1] == '0) && (s_r[2] == '0);
      qacc_r <= '0;
    end else begin
      if (cmd.norm_en) begin
        for (int k = 0; k < 3; k++) begin
          m_r[k] <= hi ? (m_r[k] >> 1) : (m_r[k] << 1);
        end
      end
      if (pv_r && psq_r) begin
        qacc_r <= qacc_r + prod_r;
      end
    end
  end

  // bit pair square root
  logic [PRW-1:0] srem_r;
  logic [RTW-1:0] sr_r, sbit_r, s_sum;
  logic           s_ge;

  assign s_sum = sr_r + sbit_r;
  assign s_ge  = RTW'(srem_r) >= s_sum;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      srem_r <= qacc_r;
      sr_r   <= '0;
      sbit_r <= {1'b1, {(RTW-1){1'b0}}};
    end else if (cmd.sqrt_step) begin
      if (s_ge) begin
        srem_r <= srem_r - s_sum[PRW-1:0];
        sr_r   <= (sr_r >> 1) + sbit_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
  end

  // restoring divide, one quotient bit a cycle
  logic [VW-1:0] drem_r, dd_r;
  logic [QW-1:0] quot_r;
  logic [LW-1:0] len;
  logic [OW-1:0] nrm_r [3];

  assign len = sr_r[LW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem_r <= {1'b0, m_r[cmd.idx][NW-1:0], {FW{1'b0}}} + VW'(len[LW-1:1]);
      dd_r   <= {len, {FW{1'b0}}};
      quot_r <= '0;
    end else if (cmd.div_step) begin
      if (drem_r >= dd_r) begin
        drem_r <= drem_r - dd_r;
        quot_r <= {quot_r[QW-2:0], 1'b1};
      end else begin
        quot_r <= {quot_r[QW-2:0], 1'b0};
      end
      dd_r <= dd_r >> 1;
    end
    if (cmd.div_store) begin
      nrm_r[cmd.idx] <= neg_r[cmd.idx] ? -{1'b0, quot_r} : {1'b0, quot_r};
    end
  end

  // output register
  logic              out_valid_r;
  gvn_pkg::gvn_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.normal_x     <= zero_r ? '0 : nrm_r[0];
      out_r.normal_y     <= zero_r ? '0 : nrm_r[1];
      out_r.normal_z     <= zero_r ? '0 : nrm_r[2];
      out_r.zero_normal  <= zero_r;
      out_r.last_of_grid <= last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.zero     = zero_r;
  assign sts.norm_ok  = !hi && or_m[NW-1];
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

### src/gvn_ctrl.sv
// grid vertex normals: controller
// configuration registers, stream position counters and sequencing state machine
// depends on gvn_pkg
module gvn_ctrl #(
  parameter int MAX_U = gvn_pkg::MAX_U_DEF,
  parameter int MAX_V = gvn_pkg::MAX_V_DEF,
  parameter int MAX_T = gvn_pkg::MAX_T_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gvn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gvn_pkg::CFG_DATA_W-1:0]  cfg_data,
  output gvn_pkg::gvn_cmd_t               cmd,
  output logic [$clog2(2*MAX_U*MAX_T+1)-1:0] rd_off,
  input  gvn_pkg::gvn_sts_t               sts
);

  localparam int WIN = 2 * MAX_U * MAX_T + 1;
  localparam int AW  = $clog2(WIN);
  localparam int LW  = $clog2(MAX_U * MAX_T + 1);
  localparam int UEW = $clog2(MAX_U + 1);
  localparam int VEW = $clog2(MAX_V + 1);
  localparam int TEW = $clog2(MAX_T + 1);
  localparam int CW  = $clog2(MAX_U);
  localparam int RW  = $clog2(MAX_V);
  localparam int TW  = (MAX_T > 1) ? $clog2(MAX_T) : 1;
  localparam int KW  = gvn_pkg::CNT_W;

  gvn_pkg::gvn_state_t state_r, state_nxt;

  logic [gvn_pkg::CFG_DATA_W-1:0] gw_r, gw_nxt, gh_r, gh_nxt;
  logic [2:0]                     ts_r, ts_nxt;
  logic [CW-1:0]                  col_r, col_nxt;
  logic [RW-1:0]                  row_r, row_nxt;
  logic [TW-1:0]                  tix_r, tix_nxt;
  logic [LW-1:0]                  pend_r, pend_nxt;
  logic [KW-1:0]                  cnt_r, cnt_nxt;
  logic [1:0]                     k_r, k_nxt;
  logic [AW-1:0]                  off_r [gvn_pkg::N_READS];
  logic [AW-1:0]                  off_nxt [gvn_pkg::N_READS];

  // effective (clamped) geometry
  logic [UEW-1:0] w_eff;
  logic [VEW-1:0] h_eff;
  logic [TEW-1:0] t_eff;
  logic [LW-1:0]  row_len;
  logic [AW-1:0]  rl_a, t_a, q_a, qm1, qpt;

  always_comb begin
    if (gw_r < 7'd2) begin
      w_eff = UEW'(2);
    end else if (32'(gw_r) > MAX_U) begin
      w_eff = UEW'(MAX_U);
    end else begin
      w_eff = UEW'(gw_r);
    end
    if (gh_r < 7'd2) begin
      h_eff = VEW'(2);
    end else if (32'(gh_r) > MAX_V) begin
      h_eff = VEW'(MAX_V);
    end else begin
      h_eff = VEW'(gh_r);
    end
    if (ts_r == 3'd0) begin
      t_eff = TEW'(1);
    end else if (32'(ts_r) > MAX_T) begin
      t_eff = TEW'(MAX_T);
    end else begin
      t_eff = TEW'(ts_r);
    end
  end

  assign row_len = LW'(w_eff) * LW'(t_eff);
  assign rl_a    = AW'(row_len);
  assign t_a     = AW'(t_eff);
  assign q_a     = AW'(pend_r);
  assign qm1     = q_a - AW'(1);
  assign qpt     = qm1 + t_a;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gvn_pkg::S_IDLE;
      gw_r    <= 7'd2;
      gh_r    <= 7'd2;
      ts_r    <= 3'd1;
      col_r   <= '0;
      row_r   <= '0;
      tix_r   <= '0;
      pend_r  <= '0;
      cnt_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      gw_r    <= gw_nxt;
      gh_r    <= gh_nxt;
      ts_r    <= ts_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      tix_r   <= tix_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
  end

  always_comb begin
    logic accept;
    state_nxt = state_r;
    gw_nxt    = gw_r;
    gh_nxt    = gh_r;
    ts_nxt    = ts_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    tix_nxt   = tix_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    off_nxt   = off_r;
    cmd       = '0;
    cmd.idx   = k_r;
    cmd.term  = cnt_r[2:0];
    cmd.rd_sel = cnt_r[2:0];
    rd_off    = off_r[cnt_r[2:0]];
    in_stall  = (state_r != gvn_pkg::S_IDLE);
    accept    = in_valid && !in_stall;

    case (state_r)
      gvn_pkg::S_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (in_command == gvn_pkg::CMD_FLUSH) begin
            if (pend_r != '0) begin
              // drain one result of the last row
              cmd.ld_flags = 1'b1;
              cmd.av[0]    = q_a > t_a;
              cmd.av[1]    = 1'b0;
              cmd.av[2]    = qpt < rl_a;
              cmd.av[3]    = 1'b1;
              cmd.last     = (pend_r == LW'(1));
              off_nxt[0]   = qm1;
              off_nxt[1]   = (q_a > t_a) ? qm1 - t_a : '0;
              off_nxt[2]   = '0;
              off_nxt[3]   = (qpt < rl_a) ? qpt : '0;
              off_nxt[4]   = qm1 + rl_a;
              pend_nxt     = pend_r - LW'(1);
              state_nxt    = gvn_pkg::S_READ;
            end
          end else begin
            cmd.wr_en = 1'b1;
            pend_nxt  = '0;
            if (row_r != '0) begin
              // result for the sample one row above
              cmd.ld_flags = 1'b1;
              cmd.av[0]    = (UEW'(col_r) + UEW'(1)) < w_eff;
              cmd.av[1]    = 1'b1;
              cmd.av[2]    = col_r != '0;
              cmd.av[3]    = row_r > RW'(1);
              cmd.last     = 1'b0;
              off_nxt[0]   = rl_a;
              off_nxt[1]   = cmd.av[0] ? rl_a - t_a : '0;
              off_nxt[2]   = '0;
              off_nxt[3]   = cmd.av[2] ? rl_a + t_a : '0;
              off_nxt[4]   = cmd.av[3] ? rl_a + rl_a : '0;
              state_nxt    = gvn_pkg::S_READ;
            end
            // advance the stream position
            if ((TEW'(tix_r) + TEW'(1)) >= t_eff) begin
              tix_nxt = '0;
              if ((UEW'(col_r) + UEW'(1)) >= w_eff) begin
                col_nxt = '0;
                if ((VEW'(row_r) + VEW'(1)) >= h_eff) begin
                  row_nxt  = '0;
                  pend_nxt = row_len;
                end else begin
                  row_nxt = row_r + RW'(1);
                end
              end else begin
                col_nxt = col_r + CW'(1);
              end
            end else begin
              tix_nxt = tix_r + TW'(1);
            end
          end
        end
      end
      gvn_pkg::S_READ: begin
        cmd.rd_en = 1'b1;
        if (cnt_r == KW'(gvn_pkg::N_READS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = gvn_pkg::S_RDWAIT;
        end else begin
          cnt_nxt = cnt_r + KW'(1);
        end
      end
      gvn_pkg::S_RDWAIT: begin
        cnt_nxt   = '0;
        k_nxt     = '0;
        state_nxt = gvn_pkg::S_CROSS;
      end
      gvn_pkg::S_CROSS: begin
        cmd.mul_en = 1'b1;
        if (cnt_r == KW'(gvn_pkg::N_TERMS - 1)) begin
          cnt_nxt = '0;
          k_nxt   = k_r + 2'd1;
          if (k_r == 2'(gvn_pkg::N_PAIRS - 1)) begin
            state_nxt = gvn_pkg::S_CROSS_ACC;
          end
        end else begin
          cnt_nxt = cnt_r + KW'(1);
        end
      end
      gvn_pkg::S_CROSS_ACC: begin
        state_nxt = gvn_pkg::S_ABS;
      end
      gvn_pkg::S_ABS: begin
        cmd.abs_en = 1'b1;
        state_nxt  = gvn_pkg::S_NORM;
      end
      gvn_pkg::S_NORM: begin
        k_nxt = '0;
        if (sts.zero) begin
          state_nxt = gvn_pkg::S_OUT;
        end else if (sts.norm_ok) begin
          state_nxt = gvn_pkg::S_SQ;
        end else begin
          cmd.norm_en = 1'b1;
        end
      end
      gvn_pkg::S_SQ: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sq = 1'b1;
        if (k_r == 2'(gvn_pkg::N_COMP - 1)) begin
          k_nxt     = '0;
          state_nxt = gvn_pkg::S_SQ_ACC;
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      gvn_pkg::S_SQ_ACC: begin
        state_nxt = gvn_pkg::S_SQRT_INIT;
      end
      gvn_pkg::S_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = gvn_pkg::S_SQRT;
      end
      gvn_pkg::S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == KW'(gvn_pkg::SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          k_nxt     = '0;
          state_nxt = gvn_pkg::S_DIV_INIT;
        end else begin
          cnt_nxt = cnt_r + KW'(1);
        end
      end
      gvn_pkg::S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = gvn_pkg::S_DIV;
      end
      gvn_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == KW'(gvn_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = gvn_pkg::S_DIV_ST;
        end else begin
          cnt_nxt = cnt_r + KW'(1);
        end
      end
      gvn_pkg::S_DIV_ST: begin
        cmd.div_store = 1'b1;
        if (k_r == 2'(gvn_pkg::N_COMP - 1)) begin
          state_nxt = gvn_pkg::S_OUT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = gvn_pkg::S_DIV_INIT;
        end
      end
      gvn_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = gvn_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gvn_pkg::S_IDLE;
      end
    endcase

    // register writes restart the stream, the window is kept
    if (cfg_valid) begin
      case (cfg_index)
        gvn_pkg::REG_GRID_WIDTH: begin
          gw_nxt = cfg_data;
        end
        gvn_pkg::REG_GRID_HEIGHT: begin
          gh_nxt = cfg_data;
        end
        gvn_pkg::REG_TIME_SAMPLES: begin
          ts_nxt = cfg_data[2:0];
        end
        default: ;
      endcase
      if (cfg_index == gvn_pkg::REG_GRID_WIDTH || cfg_index == gvn_pkg::REG_GRID_HEIGHT ||
          cfg_index == gvn_pkg::REG_TIME_SAMPLES) begin
        col_nxt  = '0;
        row_nxt  = '0;
        tix_nxt  = '0;
        pend_nxt = '0;
      end
    end
  end

endmodule

### src/grid_vertex_normals.sv
// grid vertex normals: top level
// joins the controller and the datapath
// depends on gvn_pkg, gvn_ctrl, gvn_dp
//
// usage
//   input channel (in_valid / in_stall / in_data) takes one command per transfer:
//   push a vertex sample (storage order: time sample, then column, then row) or
//   flush one pending result of the grid's last row
//   result channel (out_valid / out_stall / out_data) carries unit normals in Q1.14;
//   results lag the input by one row, the last row comes out on flush commands
//   configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) sets grid width,
//   grid height and time samples; cfg_ready is always high and a write restarts the
//   stream position, write only while idle
// sequencing
//   a push that yields no result (first row) and a flush with nothing pending
//   leave in_stall low
//   an item with a result holds in_stall high until its result is loaded; it takes
//   five window reads and 24 cross terms on the shared multiplier, then, unless the
//   summed cross product is zero, normalise shifts (up to 29), 3 squares on the
//   shared multiplier, the 32-step square root and three 15-step divides
//   one item is worked on at a time
// reset
//   synchronous active-low reset clears the stream position, pending count and
//   output valid; the window memory is not cleared
// back-pressure
//   the output register holds a result while out_stall is high and the block still
//   takes the next item; a following result waits in its last state until the
//   output register is free
module grid_vertex_normals #(
  parameter int MAX_U = gvn_pkg::MAX_U_DEF,
  parameter int MAX_V = gvn_pkg::MAX_V_DEF,
  parameter int MAX_T = gvn_pkg::MAX_T_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gvn_pkg::gvn_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output gvn_pkg::gvn_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gvn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gvn_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(2 * MAX_U * MAX_T + 1);

  // command and status between controller and datapath
  gvn_pkg::gvn_cmd_t cmd;
  gvn_pkg::gvn_sts_t sts;
  logic [AW-1:0]     rd_off;

  gvn_ctrl #(
    .MAX_U (MAX_U),
    .MAX_V (MAX_V),
    .MAX_T (MAX_T)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_data.command),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .rd_off     (rd_off),
    .sts        (sts)
  );

  gvn_dp #(
    .MAX_U (MAX_U),
    .MAX_T (MAX_T)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .rd_off    (rd_off),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### src/gvn_checker.sv
// grid vertex normals: port checker and its bind
// watches the result channel of the top level
// depends on gvn_pkg, grid_vertex_normals
module gvn_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input gvn_pkg::gvn_out_t out_data
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_normal |->
      out_data.normal_x == 16'sd0 && out_data.normal_y == 16'sd0 &&
      out_data.normal_z == 16'sd0)
    else $error("zero normal flag with non-zero components");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_data.normal_x >= -16'sd16384 && out_data.normal_x <= 16'sd16384 &&
      out_data.normal_y >= -16'sd16384 && out_data.normal_y <= 16'sd16384 &&
      out_data.normal_z >= -16'sd16384 && out_data.normal_z <= 16'sd16384)
    else $error("normal component outside unit range");

endmodule

bind grid_vertex_normals gvn_checker u_gvn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
